// ===== src/cpu16_pkg.sv =====
`timescale 1ns / 1ps
package cpu16_pkg;

    localparam int REG_COUNT_DEF       = 32;
    localparam int FLAG_REG_INDEX_DEF  = 31;
    localparam int STACK_REG_INDEX_DEF = 30;
    localparam int EXT_REG_INDEX_DEF   = 29;

    localparam logic [15:0] IRQ_VECTOR = 16'h0002;

    typedef enum logic [2:0] {
        PH_FETCH  = 3'd0,
        PH_IDLE   = 3'd1,
        PH_EXEC   = 3'd2,
        PH_CONTD  = 3'd3,
        PH_CONTD2 = 3'd4
    } phase_t;

    typedef enum logic [5:0] {
        OP_MVI  = 6'h00, OP_MVR = 6'h01, OP_XCH = 6'h02, OP_LDR = 6'h03,
        OP_STI  = 6'h04, OP_STR = 6'h05, OP_ADD = 6'h06, OP_SUB = 6'h07,
        OP_CMP  = 6'h08, OP_MUL = 6'h09, OP_INC = 6'h0A, OP_DEC = 6'h0B,
        OP_XOR  = 6'h0C, OP_AND = 6'h0D, OP_OR  = 6'h0E, OP_SHL = 6'h0F,
        OP_SHR  = 6'h10, OP_JMP = 6'h11, OP_PSI = 6'h12, OP_PSH = 6'h13,
        OP_POP  = 6'h14, OP_HLT = 6'h15, OP_RET = 6'h16, OP_LDI = 6'h17,
        OP_CALL = 6'h18
    } opcode_t;

    localparam logic [3:0] CC_ALWAYS = 4'h0;
    localparam logic [3:0] CC_NZ     = 4'h1;
    localparam logic [3:0] CC_CZ     = 4'h2;
    localparam logic [3:0] CC_C      = 4'h3;
    localparam logic [3:0] CC_NC     = 4'h4;
    localparam logic [3:0] CC_NCNZ   = 4'h5;
    localparam logic [3:0] CC_Z      = 4'h6;
    localparam logic [3:0] CC_LE     = 4'hA;
    localparam logic [3:0] CC_LT     = 4'hB;
    localparam logic [3:0] CC_GE     = 4'hC;
    localparam logic [3:0] CC_GT     = 4'hD;

    // alu request/result between sequencer and alu
    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [4:0]  shamt;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic        z;
        logic        s;
        logic        c;
        logic        v;
    } alu_res_t;

    function automatic logic jump_ok(input logic [3:0] cond, input logic [15:0] f);
        logic z, s, c, o;
        z = f[0]; s = f[1]; c = f[2]; o = f[3];
        case (cond)
            CC_ALWAYS: jump_ok = 1'b1;
            CC_Z:      jump_ok = z;
            CC_NZ:     jump_ok = !z;
            CC_GT:     jump_ok = ((!s) ^ o) && !z;
            CC_GE:     jump_ok = (!s) ^ o;
            CC_LT:     jump_ok = s ^ o;
            CC_LE:     jump_ok = (s ^ o) || z;
            CC_NCNZ:   jump_ok = !c && !z;
            CC_NC:     jump_ok = !c;
            CC_C:      jump_ok = c;
            CC_CZ:     jump_ok = c || z;
            default:   jump_ok = 1'b0;
        endcase
    endfunction

endpackage

// ===== src/cpu16_alu.sv =====
`timescale 1ns / 1ps
module cpu16_alu
    import cpu16_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    logic [16:0] sum;
    logic [16:0] dif;
    logic [31:0] prod;
    logic [15:0] nb;
    logic        bo;

    assign sum  = {1'b0, req.a} + {1'b0, req.b};
    assign dif  = {1'b0, req.a} - {1'b0, req.b};
    assign prod = req.a * req.b;
    assign nb   = 16'h0000 - req.b;

    always_comb
    begin
        res = '0;
        case (req.op)
            OP_ADD, OP_SUB, OP_CMP:
            begin
                if (req.op == OP_ADD)
                begin
                    res.lo = sum[15:0];
                    res.c  = sum[16];
                    bo     = req.b[15];
                end
                else
                begin
                    res.lo = dif[15:0];
                    res.c  = dif[16];
                    // bit 15 of 0x10000 - b
                    bo     = (req.b == 16'h0000) ? 1'b0 : nb[15];
                end
                res.z = (res.lo == 16'h0000);
                res.s = res.lo[15];
                res.v = (res.s && !req.a[15] && !bo) || (!res.s && req.a[15] && bo);
            end
            OP_MUL:
            begin
                bo     = 1'b0;
                res.lo = prod[15:0];
                res.hi = prod[31:16];
                res.z  = (prod == 32'd0);
                res.s  = prod[31];
                res.c  = (prod[31:16] != 16'h0000);
            end
            OP_XOR, OP_AND, OP_OR:
            begin
                bo = 1'b0;
                if (req.op == OP_XOR)
                    res.lo = req.a ^ req.b;
                else if (req.op == OP_AND)
                    res.lo = req.a & req.b;
                else
                    res.lo = req.a | req.b;
                res.z = (res.lo == 16'h0000);
                res.s = res.lo[15];
            end
            OP_DEC:
            begin
                bo     = 1'b0;
                res.lo = req.a - 16'd1;
                res.z  = (res.lo == 16'h0000);
            end
            OP_SHL:
            begin
                bo     = 1'b0;
                res.lo = req.shamt[4] ? 16'h0000 : (req.a << req.shamt[3:0]);
            end
            OP_SHR:
            begin
                bo     = 1'b0;
                res.lo = req.shamt[4] ? 16'h0000 : (req.a >> req.shamt[3:0]);
            end
            default:
            begin
                bo     = 1'b0;
                res.lo = req.a + 16'd1;
            end
        endcase
    end

endmodule

// ===== src/cpu16_core_step.sv =====
`timescale 1ns / 1ps
module cpu16_core_step
    import cpu16_pkg::*;
#(
    parameter int REG_COUNT       = REG_COUNT_DEF,
    parameter int FLAG_REG_INDEX  = FLAG_REG_INDEX_DEF,
    parameter int STACK_REG_INDEX = STACK_REG_INDEX_DEF,
    parameter int EXT_REG_INDEX   = EXT_REG_INDEX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [15:0] mem_read_word,
    input  logic        irq_line,
    input  logic        halt_line,
    input  logic [4:0]  debug_select,
    output logic [15:0] bus_address,
    output logic        bus_write,
    output logic [15:0] bus_write_word,
    output logic [15:0] debug_value
);

    localparam int RW = $clog2(REG_COUNT);
    localparam logic [RW-1:0] FI = RW'(FLAG_REG_INDEX);
    localparam logic [RW-1:0] SI = RW'(STACK_REG_INDEX);
    localparam logic [RW-1:0] EI = RW'(EXT_REG_INDEX);

    logic [15:0] rf_reg [REG_COUNT];
    logic [15:0] rf_next [REG_COUNT];
    logic [15:0] ip_reg, ip_next;
    phase_t      ph_reg, ph_next, paw_reg, paw_next;
    logic        pirq_reg, pirq_next;
    logic [5:0]  hop_reg, hop_next;
    logic [4:0]  hdst_reg, hdst_next, hsrc_reg, hsrc_next;
    logic [15:0] hsv_reg, hsv_next;
    logic [15:0] addr_reg, addr_next;
    logic        wf_reg, wf_next;
    logic [15:0] ww_reg, ww_next;
    logic [15:0] lrw_reg;
    logic [15:0] dbg_reg, dbg_next;

    logic [15:0] lrw;
    logic [5:0]  op;
    logic [4:0]  dst, src;
    logic [15:0] dv, sv, sp, ip1, fl;
    alu_req_t    areq;
    alu_res_t    ares;

    // read word bypass: the previous bus cycle completes first
    assign lrw = wf_reg ? lrw_reg : mem_read_word;
    assign op  = lrw[5:0];
    assign dst = lrw[10:6];
    assign src = lrw[15:11];
    assign dv  = rf_reg[dst[RW-1:0]];
    assign sv  = rf_reg[src[RW-1:0]];
    assign sp  = rf_reg[SI];
    assign fl  = rf_reg[FI];
    assign ip1 = ip_reg + 16'd1;

    assign areq.op    = op;
    assign areq.a     = dv;
    assign areq.b     = sv;
    assign areq.shamt = src;

    cpu16_alu u_alu (.req(areq), .res(ares));

    always_comb
    begin
        rf_next   = rf_reg;
        ip_next   = ip_reg;
        ph_next   = ph_reg;
        paw_next  = paw_reg;
        pirq_next = pirq_reg;
        hop_next  = hop_reg;
        hdst_next = hdst_reg;
        hsrc_next = hsrc_reg;
        hsv_next  = hsv_reg;
        addr_next = addr_reg;
        wf_next   = wf_reg;
        ww_next   = ww_reg;
        case (ph_reg)
            PH_FETCH:
            begin
                if (irq_line && !pirq_reg && fl[4])
                begin
                    addr_next   = sp - 16'd1;
                    wf_next     = 1'b1;
                    ww_next     = ip_reg;
                    rf_next[SI] = sp - 16'd1;
                    ip_next     = IRQ_VECTOR;
                    paw_next    = PH_FETCH;
                    ph_next     = PH_IDLE;
                end
                else if (!halt_line)
                begin
                    addr_next = ip_reg;
                    wf_next   = 1'b0;
                    ph_next   = PH_IDLE;
                    paw_next  = PH_EXEC;
                end
                pirq_next = irq_line;
            end
            PH_IDLE: ph_next = paw_reg;
            PH_EXEC:
            begin
                hop_next  = op;
                hdst_next = dst;
                hsrc_next = src;
                hsv_next  = sv;
                ph_next   = PH_FETCH;
                ip_next   = ip1;
                case (op)
                    OP_MVI, OP_STI, OP_LDI:
                    begin
                        addr_next = ip1; ip_next = ip_reg;
                        ph_next = PH_IDLE; paw_next = PH_CONTD;
                    end
                    OP_LDR:
                    begin
                        addr_next = sv; ip_next = ip_reg;
                        ph_next = PH_IDLE; paw_next = PH_CONTD;
                    end
                    OP_STR:
                    begin
                        addr_next = dv; ww_next = sv; wf_next = 1'b1;
                        ph_next = PH_IDLE; paw_next = PH_FETCH;
                    end
                    OP_MVR: rf_next[dst[RW-1:0]] = sv;
                    OP_XCH:
                    begin
                        rf_next[src[RW-1:0]] = dv;
                        rf_next[dst[RW-1:0]] = sv;
                    end
                    OP_ADD, OP_SUB, OP_CMP, OP_XOR, OP_AND, OP_OR:
                    begin
                        if (op != OP_CMP)
                            rf_next[dst[RW-1:0]] = ares.lo;
                        rf_next[FI][0] = ares.z;
                        rf_next[FI][1] = ares.s;
                        rf_next[FI][2] = ares.c;
                        if (op == OP_ADD || op == OP_SUB || op == OP_CMP)
                            rf_next[FI][3] = ares.v;
                    end
                    OP_MUL:
                    begin
                        rf_next[dst[RW-1:0]] = ares.lo;
                        rf_next[EI]    = ares.hi;
                        rf_next[FI][0] = ares.z;
                        rf_next[FI][1] = ares.s;
                        rf_next[FI][2] = ares.c;
                    end
                    OP_INC, OP_SHL, OP_SHR: rf_next[dst[RW-1:0]] = ares.lo;
                    OP_DEC:
                    begin
                        rf_next[dst[RW-1:0]] = ares.lo;
                        rf_next[FI][0] = ares.z;
                    end
                    OP_JMP:
                    begin
                        if (jump_ok(src[3:0], fl))
                        begin
                            if (src[4])
                            begin
                                addr_next = ip1; ip_next = ip_reg;
                                ph_next = PH_IDLE; paw_next = PH_CONTD;
                            end
                            else
                                ip_next = dv;
                        end
                        else
                            ip_next = ip_reg + (src[4] ? 16'd2 : 16'd1);
                    end
                    OP_PSI:
                    begin
                        addr_next = ip1; ip_next = ip_reg;
                        rf_next[SI] = sp - 16'd1;
                        ph_next = PH_IDLE; paw_next = PH_CONTD;
                    end
                    OP_PSH:
                    begin
                        addr_next = sp - 16'd1; ww_next = dv; wf_next = 1'b1;
                        rf_next[SI] = sp - 16'd1;
                        ph_next = PH_IDLE; paw_next = PH_FETCH;
                    end
                    OP_POP, OP_RET:
                    begin
                        addr_next = sp; ip_next = ip_reg;
                        rf_next[SI] = sp + 16'd1;
                        ph_next = PH_IDLE; paw_next = PH_CONTD;
                    end
                    OP_HLT: ip_next = ip_reg;
                    OP_CALL:
                    begin
                        addr_next = sp - 16'd1; wf_next = 1'b1;
                        rf_next[SI] = sp - 16'd1;
                        ph_next = PH_IDLE;
                        if (src[4])
                        begin
                            ww_next = ip_reg + 16'd2; ip_next = ip_reg;
                            paw_next = PH_CONTD;
                        end
                        else
                        begin
                            ww_next = ip1; ip_next = dv;
                            paw_next = PH_FETCH;
                        end
                    end
                    default:
                    begin
                        // unknown opcode: decode the same word again
                        ip_next = ip_reg;
                        ph_next = PH_EXEC;
                    end
                endcase
            end
            PH_CONTD:
            begin
                case (hop_reg)
                    OP_MVI:
                    begin
                        rf_next[hdst_reg[RW-1:0]] = lrw;
                        ip_next = ip_reg + 16'd2; ph_next = PH_FETCH;
                    end
                    OP_LDR, OP_POP:
                    begin
                        rf_next[hdst_reg[RW-1:0]] = lrw;
                        ip_next = ip1; ph_next = PH_FETCH;
                    end
                    OP_STI:
                    begin
                        addr_next = lrw; ww_next = hsv_reg; wf_next = 1'b1;
                        ip_next = ip_reg + 16'd2;
                        ph_next = PH_IDLE; paw_next = PH_FETCH;
                    end
                    OP_JMP, OP_RET:
                    begin
                        ip_next = lrw; ph_next = PH_FETCH;
                    end
                    OP_PSI:
                    begin
                        addr_next = sp; ww_next = lrw; wf_next = 1'b1;
                        ip_next = ip_reg + 16'd2;
                        ph_next = PH_IDLE; paw_next = PH_FETCH;
                    end
                    OP_LDI:
                    begin
                        addr_next = lrw;
                        ph_next = PH_IDLE; paw_next = PH_CONTD2;
                    end
                    OP_CALL:
                    begin
                        addr_next = ip1; wf_next = 1'b0;
                        ph_next = PH_IDLE; paw_next = PH_CONTD2;
                    end
                    default: ;
                endcase
            end
            PH_CONTD2:
            begin
                if (hop_reg == OP_LDI)
                begin
                    rf_next[hdst_reg[RW-1:0]] = lrw;
                    ip_next = ip_reg + 16'd2; ph_next = PH_FETCH;
                end
                else if (hop_reg == OP_CALL)
                begin
                    ip_next = lrw; ph_next = PH_FETCH;
                end
            end
            default: ;
        endcase
        dbg_next = rf_next[debug_select[RW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                rf_reg[i] <= '0;
            ip_reg   <= '0;
            ph_reg   <= PH_FETCH;
            paw_reg  <= PH_FETCH;
            pirq_reg <= 1'b0;
            hop_reg  <= '0;
            hdst_reg <= '0;
            hsrc_reg <= '0;
            hsv_reg  <= '0;
            addr_reg <= '0;
            wf_reg   <= 1'b0;
            ww_reg   <= '0;
            lrw_reg  <= '0;
            dbg_reg  <= '0;
        end
        else if (step)
        begin
            rf_reg   <= rf_next;
            ip_reg   <= ip_next;
            ph_reg   <= ph_next;
            paw_reg  <= paw_next;
            pirq_reg <= pirq_next;
            hop_reg  <= hop_next;
            hdst_reg <= hdst_next;
            hsrc_reg <= hsrc_next;
            hsv_reg  <= hsv_next;
            addr_reg <= addr_next;
            wf_reg   <= wf_next;
            ww_reg   <= ww_next;
            lrw_reg  <= lrw;
            dbg_reg  <= dbg_next;
        end
    end

    assign bus_address    = addr_reg;
    assign bus_write      = wf_reg;
    assign bus_write_word = ww_reg;
    assign debug_value    = dbg_reg;

endmodule

// ===== src/cpu16_multicycle_core.sv =====
`timescale 1ns / 1ps
// 16-bit multicycle core stepped by a stream: each input beat is one bus cycle (read word,
// irq level, halt level, debug register select) and yields exactly one output beat
// (next bus address, write enable, write data, selected register after the step). one
// beat is taken every clock; the architectural state and the result register update in
// the same cycle, with all decode, alu and sequencing between the input beat and that
// register. the result register is freed in the cycle it is taken, so the input side
// stays ready while the output is accepted, and stalls only while a result waits
module cpu16_multicycle_core
    import cpu16_pkg::*;
#(
    parameter int REG_COUNT       = REG_COUNT_DEF,
    parameter int FLAG_REG_INDEX  = FLAG_REG_INDEX_DEF,
    parameter int STACK_REG_INDEX = STACK_REG_INDEX_DEF,
    parameter int EXT_REG_INDEX   = EXT_REG_INDEX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // mem_read_word, irq_line, halt_line, debug_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // bus_address, bus_write, bus_write_word, debug_value
);

    logic        step;
    logic        ovalid_reg;
    logic [15:0] addr, wword, dval;
    logic        wr;

    // a new beat enters when the result slot is empty or being drained
    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    cpu16_core_step #(
        .REG_COUNT      (REG_COUNT),
        .FLAG_REG_INDEX (FLAG_REG_INDEX),
        .STACK_REG_INDEX(STACK_REG_INDEX),
        .EXT_REG_INDEX  (EXT_REG_INDEX)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .mem_read_word (s_axis_tdata[15:0]),
        .irq_line      (s_axis_tdata[16]),
        .halt_line     (s_axis_tdata[17]),
        .debug_select  (s_axis_tdata[22:18]),
        .bus_address   (addr),
        .bus_write     (wr),
        .bus_write_word(wword),
        .debug_value   (dval)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (step)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, dval, wword, wr, addr};

endmodule
